// File: rtl/core/efq_pkg.sv
// efq_pkg: shared constants, entry type and helper functions for the event table
// no dependencies; used by the interfaces, the cell and the top level
package efq_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int NUM_CODES   = 28;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    localparam int CODE_W = 8;
    localparam int CNT_W  = 8;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 4;

    localparam logic OP_LOG  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [CNT_W-1:0]  count;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    // codes at or above the code range collapse to code 0
    function automatic logic [CODE_W-1:0] f_map_code(input logic [CODE_W-1:0] code);
        logic [CODE_W:0] wide;
        wide = {1'b0, code};
        return (wide >= (CODE_W+1)'(NUM_CODES)) ? '0 : code;
    endfunction

    // read slot wraps at the table depth (a 16 entry lookup in hardware)
    function automatic t_idx f_read_idx(input logic [SLOT_W-1:0] slot);
        return IDX_W'(32'(slot) % TABLE_DEPTH);
    endfunction

    function automatic logic [SLOT_W-1:0] f_slot_out(input t_idx idx);
        return SLOT_W'(idx);
    endfunction

endpackage

// File: rtl/core/efq_if.sv
// efq_in_if / efq_out_if: valid-ready channels for log/read requests and results
// depends on efq_pkg for field widths
interface efq_in_if
    import efq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                op;
    logic [CODE_W-1:0]   event_code;
    logic [TIME_W-1:0]   event_time;
    logic                use_newest;
    logic [SLOT_W-1:0]   read_slot;

    modport source (output valid, op, event_code, event_time, use_newest, read_slot,
                    input ready);
    modport sink   (input valid, op, event_code, event_time, use_newest, read_slot,
                    output ready);
endinterface

interface efq_out_if
    import efq_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [SLOT_W-1:0]   slot;
    logic                inserted;
    logic [CODE_W-1:0]   entry_code;
    logic [CNT_W-1:0]    entry_count;
    logic [TIME_W-1:0]   entry_time;

    modport source (output valid, slot, inserted, entry_code, entry_count, entry_time,
                    input ready);
    modport sink   (input valid, slot, inserted, entry_code, entry_count, entry_time,
                    output ready);
endinterface

// File: rtl/core/event_frequency_table_top.sv
// Event frequency table: TABLE_DEPTH slots of {code, 8-bit count, 32-bit time}, cleared at
// reset. One request is in flight at a time. A read registers its slot and moves to S_LOAD,
// which loads the output register once that register is free. A log sends a search token
// down the row of cells, one cell per cycle; a hit in slot k, or a miss (which writes the
// slot after the ring pointer) once the token leaves the last cell, likewise moves to
// S_LOAD. A new request is taken as soon as the result sits in the output register.
// Depends on efq_pkg, efq_in_if/efq_out_if and efq_cell.
module event_frequency_table_top
    import efq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    efq_in_if.sink    i_in,
    efq_out_if.source o_out
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_LOAD = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [CODE_W-1:0] r_code, n_code;
    logic [TIME_W-1:0] r_time, n_time;
    t_idx              r_slot, n_slot;
    t_idx              r_ptr, n_ptr;
    logic              r_ins, n_ins;
    logic              r_start, n_start;

    logic              r_ovalid, n_ovalid;
    logic [SLOT_W-1:0] r_oslot, n_oslot;
    logic              r_oins, n_oins;
    t_entry            r_oent, n_oent;

    logic [TABLE_DEPTH:0]   tok;
    logic [TABLE_DEPTH-1:0] hit;
    logic [TABLE_DEPTH-1:0] wr;
    t_entry                 entries [TABLE_DEPTH];
    t_idx                   hit_idx;
    t_idx                   ptr_next;
    logic                   in_beat;
    logic                   miss;

    assign tok[0]  = r_start;
    assign in_beat = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            efq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_tok   (tok[g]),
                .i_code  (r_code),
                .i_time  (r_time),
                .i_wr    (wr[g]),
                .o_tok   (tok[g+1]),
                .o_hit   (hit[g]),
                .o_entry (entries[g])
            );
        end
    endgenerate

    always_comb begin
        hit_idx = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (hit[k]) begin
                hit_idx = hit_idx | IDX_W'(k);
            end
        end
    end

    assign ptr_next = (r_ptr == IDX_W'(TABLE_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
    // token left the last cell without a match
    assign miss     = (r_state == S_WALK) && tok[TABLE_DEPTH];

    always_comb begin
        wr = '0;
        if (miss) begin
            wr[ptr_next] = 1'b1;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_code   = r_code;
        n_time   = r_time;
        n_slot   = r_slot;
        n_ptr    = r_ptr;
        n_ins    = r_ins;
        n_start  = 1'b0;
        n_ovalid = r_ovalid;
        n_oslot  = r_oslot;
        n_oins   = r_oins;
        n_oent   = r_oent;

        if (o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    if (i_in.op == OP_READ) begin
                        n_slot  = i_in.use_newest ? r_ptr : f_read_idx(i_in.read_slot);
                        n_ins   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_code  = f_map_code(i_in.event_code);
                        n_time  = i_in.event_time;
                        n_start = 1'b1;
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (|hit) begin
                    n_slot  = hit_idx;
                    n_ins   = 1'b0;
                    n_state = S_LOAD;
                end else if (miss) begin
                    n_ptr   = ptr_next;
                    n_slot  = ptr_next;
                    n_ins   = 1'b1;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    n_oslot  = f_slot_out(r_slot);
                    n_oins   = r_ins;
                    n_oent   = entries[r_slot];
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ptr    <= IDX_W'(TABLE_DEPTH - 1);
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_start  <= n_start;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code  <= n_code;
        r_time  <= n_time;
        r_slot  <= n_slot;
        r_ins   <= n_ins;
        r_oslot <= n_oslot;
        r_oins  <= n_oins;
        r_oent  <= n_oent;
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.slot        = r_oslot;
    assign o_out.inserted    = r_oins;
    assign o_out.entry_code  = r_oent.code;
    assign o_out.entry_count = r_oent.count;
    assign o_out.entry_time  = r_oent.stamp;

endmodule

// File: rtl/core/efq_cell.sv
// efq_cell: one table slot; holds code, count and stamp and passes the search token on
// depends on efq_pkg
module efq_cell
    import efq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_tok,
    input  logic [CODE_W-1:0] i_code,
    input  logic [TIME_W-1:0] i_time,
    input  logic              i_wr,
    output logic              o_tok,
    output logic              o_hit,
    output t_entry            o_entry
);

    logic   r_tok;
    t_entry r_entry;
    t_entry n_entry;

    assign o_hit   = r_tok && (r_entry.code == i_code);
    // token moves on only while the search has not matched
    assign o_tok   = r_tok && !o_hit;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_wr) begin
            n_entry.code  = i_code;
            n_entry.count = CNT_W'(1);
            n_entry.stamp = i_time;
        end else if (o_hit) begin
            n_entry.count = r_entry.count + 1'b1;
            n_entry.stamp = i_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= 1'b0;
            r_entry <= '0;
        end else begin
            r_tok   <= i_tok;
            r_entry <= n_entry;
        end
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// testbench for event_frequency_table_top: directed and random log/read beats,
// checked against an in-bench model of the slot table
// depends on efq_pkg, efq_in_if/efq_out_if and the top level
module testbench;
    import efq_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        logic              op;
        logic [CODE_W-1:0] event_code;
        logic [TIME_W-1:0] event_time;
        logic              use_newest;
        logic [SLOT_W-1:0] read_slot;
    } t_request;

    typedef struct {
        logic [SLOT_W-1:0] slot;
        logic              inserted;
        logic [CODE_W-1:0] entry_code;
        logic [CNT_W-1:0]  entry_count;
        logic [TIME_W-1:0] entry_time;
    } t_reply;

    // tracks the slot table and the replies still owed by the block
    class entry_tracker;
        logic [CODE_W-1:0] codes  [TABLE_DEPTH];
        logic [CNT_W-1:0]  counts [TABLE_DEPTH];
        logic [TIME_W-1:0] stamps [TABLE_DEPTH];
        int                newest_slot;
        t_reply            expected_replies[$];
        int                mismatches;
        int                n_logs, n_reads, n_inserts, n_hits, n_wraps, n_replies;

        function new();
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                codes[i]  = '0;
                counts[i] = '0;
                stamps[i] = '0;
            end
            newest_slot = TABLE_DEPTH - 1;
        endfunction

        function void log_request(t_request r);
            t_reply            exp;
            int                idx;
            bit                hit;
            logic [CODE_W-1:0] code;
            idx = 0;
            hit = 1'b0;
            exp.inserted = 1'b0;
            if (r.op == OP_READ) begin
                n_reads++;
                idx = r.use_newest ? newest_slot : int'(r.read_slot) % TABLE_DEPTH;
            end else begin
                n_logs++;
                code = (int'(r.event_code) >= NUM_CODES) ? '0 : r.event_code;
                // lowest matching slot wins
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (!hit && codes[i] == code) begin
                        hit = 1'b1;
                        idx = i;
                    end
                end
                if (hit) begin
                    n_hits++;
                    counts[idx] = counts[idx] + 1'b1;
                    if (counts[idx] == '0)
                        n_wraps++;
                end else begin
                    n_inserts++;
                    newest_slot = (newest_slot + 1) % TABLE_DEPTH;
                    idx = newest_slot;
                    codes[idx]  = code;
                    counts[idx] = CNT_W'(1);
                    exp.inserted = 1'b1;
                end
                stamps[idx] = r.event_time;
            end
            exp.slot        = SLOT_W'(idx);
            exp.entry_code  = codes[idx];
            exp.entry_count = counts[idx];
            exp.entry_time  = stamps[idx];
            expected_replies.push_back(exp);
        endfunction

        function void check_reply(t_reply got);
            t_reply exp;
            n_replies++;
            if (expected_replies.size() == 0) begin
                $display("%0t: reply with nothing owed: slot %0d code %0d count %0d",
                         $time, got.slot, got.entry_code, got.entry_count);
                mismatches++;
                return;
            end
            exp = expected_replies.pop_front();
            if (got.slot !== exp.slot) begin
                $display("%0t: slot exp %0d got %0d", $time, exp.slot, got.slot);
                mismatches++;
            end
            if (got.inserted !== exp.inserted) begin
                $display("%0t: inserted exp %0b got %0b", $time, exp.inserted, got.inserted);
                mismatches++;
            end
            if (got.entry_code !== exp.entry_code) begin
                $display("%0t: entry_code exp %0d got %0d", $time,
                         exp.entry_code, got.entry_code);
                mismatches++;
            end
            if (got.entry_count !== exp.entry_count) begin
                $display("%0t: entry_count exp %0d got %0d", $time,
                         exp.entry_count, got.entry_count);
                mismatches++;
            end
            if (got.entry_time !== exp.entry_time) begin
                $display("%0t: entry_time exp %h got %h", $time,
                         exp.entry_time, got.entry_time);
                mismatches++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    efq_in_if  in_ch ();
    efq_out_if out_ch ();

    event_frequency_table_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    entry_tracker tracker = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d replies still owed",
                     cycle_count, tracker.expected_replies.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when asked for
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : watch_replies
        t_reply got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.slot        = out_ch.slot;
            got.inserted    = out_ch.inserted;
            got.entry_code  = out_ch.entry_code;
            got.entry_count = out_ch.entry_count;
            got.entry_time  = out_ch.entry_time;
            tracker.check_reply(got);
        end
    end

    function automatic t_request log_req(input logic [CODE_W-1:0] code,
                                         input logic [TIME_W-1:0] stamp);
        t_request r;
        r.op         = OP_LOG;
        r.event_code = code;
        r.event_time = stamp;
        r.use_newest = 1'($urandom);
        r.read_slot  = SLOT_W'($urandom);
        return r;
    endfunction

    function automatic t_request read_req(input logic newest, input logic [SLOT_W-1:0] slot);
        t_request r;
        r.op         = OP_READ;
        r.event_code = CODE_W'($urandom);
        r.event_time = $urandom;
        r.use_newest = newest;
        r.read_slot  = slot;
        return r;
    endfunction

    function automatic t_request random_req();
        int               pick;
        logic [TIME_W-1:0] stamp;
        pick  = $urandom_range(99);
        stamp = ($urandom_range(19) == 0) ? {TIME_W{pick[0]}} : TIME_W'($urandom);
        if ($urandom_range(3) == 0)
            return read_req(1'($urandom), SLOT_W'($urandom_range(15)));
        // hot codes keep hits coming, the rest forces evictions and code remapping
        if (pick < 45)
            return log_req(CODE_W'($urandom_range(7)), stamp);
        else if (pick < 80)
            return log_req(CODE_W'($urandom_range(NUM_CODES - 1)), stamp);
        return log_req(CODE_W'($urandom_range(255)), stamp);
    endfunction

    // one beat on the request channel, with random idle cycles ahead of it
    task automatic offer(input t_request r);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_ch.valid      <= 1'b0;
            in_ch.op         <= 1'($urandom);
            in_ch.event_code <= CODE_W'($urandom);
            in_ch.event_time <= $urandom;
            in_ch.use_newest <= 1'($urandom);
            in_ch.read_slot  <= SLOT_W'($urandom);
        end
        @(negedge i_clk);
        in_ch.valid      <= 1'b1;
        in_ch.op         <= r.op;
        in_ch.event_code <= r.event_code;
        in_ch.event_time <= r.event_time;
        in_ch.use_newest <= r.use_newest;
        in_ch.read_slot  <= r.read_slot;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        tracker.log_request(r);
    endtask

    task automatic run_phase(input int sender_pct, input int receiver_pct, input int n);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
        repeat (n)
            offer(random_req());
    endtask

    initial begin
        in_ch.valid      = 1'b0;
        in_ch.op         = OP_LOG;
        in_ch.event_code = '0;
        in_ch.event_time = '0;
        in_ch.use_newest = 1'b0;
        in_ch.read_slot  = '0;
        i_rst_n          = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // cleared table, code remapping, ring pointer wrap to slot 0
        offer(read_req(1'b0, 4'd0));
        offer(read_req(1'b1, 4'd0));
        offer(log_req(8'd0, 32'h0000_0000));
        offer(log_req(8'd255, 32'hFFFF_FFFF));
        offer(log_req(CODE_W'(NUM_CODES), 32'h0000_0001));
        offer(log_req(CODE_W'(NUM_CODES - 1), 32'h1234_5678));
        offer(log_req(8'd1, 32'h8000_0000));
        offer(log_req(CODE_W'(NUM_CODES - 1), 32'h7FFF_FFFF));
        offer(log_req(8'd0, 32'hA5A5_A5A5));
        offer(log_req(8'h80, 32'h5A5A_5A5A));
        offer(read_req(1'b1, 4'd15));
        offer(read_req(1'b0, 4'd15));
        offer(read_req(1'b0, 4'd1));
        offer(read_req(1'b0, 4'd0));
        offer(log_req(8'd26, 32'hDEAD_BEEF));
        offer(log_req(8'h7F, 32'h0F0F_0F0F));
        offer(log_req(8'd3, 32'hF0F0_F0F0));
        offer(read_req(1'b1, 4'd10));
        offer(read_req(1'b0, 4'd8));
        offer(log_req(8'd1, 32'hFFFF_FFFE));

        // hammer one code past a full count so it wraps
        repeat (258)
            offer(log_req(8'd5, $urandom));
        offer(read_req(1'b1, 4'd0));

        // receiver holds off while the sender keeps pushing
        hold_left = 300;
        run_phase(0, 0, 220);
        run_phase(78, 0, 220);
        run_phase(0, 78, 220);
        hold_left = 150;
        run_phase(21, 21, 220);

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (tracker.expected_replies.size() != 0)
            @(posedge i_clk);
        repeat (TABLE_DEPTH + 4) @(posedge i_clk);

        $display("checked %0d replies: %0d logs (%0d new entries, %0d hits, %0d count wraps)",
                 tracker.n_replies, tracker.n_logs, tracker.n_inserts, tracker.n_hits,
                 tracker.n_wraps);
        $display("%0d reads, over four idle/stall mixes and two receiver hold-offs",
                 tracker.n_reads);
        if (tracker.mismatches == 0 && tracker.expected_replies.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/efq_pkg.sv
rtl/core/efq_if.sv
rtl/core/efq_cell.sv
rtl/core/event_frequency_table_top.sv
verif/testbench.sv
